// ===== hw/rtl/keyframe_track_interpolator_macros.svh =====
// Assertion macros for the keyframe track interpolator.
// Depends on nothing; included by the top level.
`ifndef KEYFRAME_TRACK_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_TRACK_INTERPOLATOR_MACROS_SVH

// implication check, reset-gated
`define KTI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication check, reset-gated
`define KTI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/kti_pkg.sv =====
// Package for the keyframe track interpolator: widths, codes, control structs.
// Depends on nothing.
package kti_pkg;
   localparam int MaxKeys = 256;
   localparam int IdxW = $clog2(MaxKeys);
   localparam int CntW = IdxW + 1;
   localparam int TimeW = 24;
   localparam int CompW = 32;
   localparam int CmdW = 2;
   localparam int AddrW = 4;
   localparam int DivBits = 40;

   localparam logic [CmdW-1:0] CMD_WRITE = 2'd0;
   localparam logic [CmdW-1:0] CMD_SAMPLE = 2'd1;
   localparam logic [CmdW-1:0] CMD_TICK = 2'd2;

   localparam logic [AddrW-1:0] ADDR_KEY_COUNT = 4'h0;
   localparam logic [AddrW-1:0] ADDR_DURATION = 4'h4;
   localparam logic [AddrW-1:0] ADDR_STEP = 4'h8;

   typedef struct packed {
      logic             write_key;
      logic             start_tick;
      logic             start_search;
      logic             load_time;
      logic             read_key;
      logic             compare;
      logic             div_start;
      logic             blend;
      logic             load_out;
   } ctrl_type;

   typedef struct packed {
      logic             search_hit;
      logic             search_end;
      logic             tick_done;
      logic             div_done;
   } status_type;
endpackage

// ===== hw/rtl/kti_stream_if.sv =====
// Valid/ready stream interface for the keyframe track interpolator channels.
// Depends on nothing.
interface kti_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [7:0]  key_index;
   logic [23:0] key_time;
   logic signed [31:0] key_x;
   logic signed [31:0] key_y;
   logic signed [31:0] key_z;
   logic [23:0] query_time;
   modport source (output valid, command, key_index, key_time, key_x, key_y, key_z,
                   query_time, input ready);
   modport sink (input valid, command, key_index, key_time, key_x, key_y, key_z,
                 query_time, output ready);
endinterface

interface kti_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic [23:0] sampled_time;
   modport source (output valid, out_x, out_y, out_z, sampled_time, input ready);
   modport sink (input valid, out_x, out_y, out_z, sampled_time, output ready);
endinterface

// ===== hw/rtl/kti_datapath.sv =====
// Datapath: key memory, playback time, search, restoring divider, blend.
// Depends on kti_pkg.
module kti_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  kti_pkg::ctrl_type       ctrl,
   output kti_pkg::status_type     status,
   input  logic [7:0]              key_index,
   input  logic [23:0]             key_time,
   input  logic [31:0]             key_x,
   input  logic [31:0]             key_y,
   input  logic [31:0]             key_z,
   input  logic [23:0]             query_time,
   input  logic                    use_playback,
   input  logic [8:0]              key_count,
   input  logic [23:0]             track_duration,
   input  logic [23:0]             time_step,
   output logic [95:0]             res_vec,
   output logic [23:0]             res_time
);
   import kti_pkg::*;

   logic [TimeW-1:0] times_mem [MaxKeys];
   logic [3*CompW-1:0] vec_mem [MaxKeys];
   logic [TimeW-1:0] rd_time_ff;
   logic [3*CompW-1:0] rd_vec_ff;
   logic [IdxW-1:0] rd_addr;

   logic [TimeW-1:0] play_ff, play_in;
   logic [TimeW-1:0] sample_ff, sample_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic [CntW-1:0] n_use;
   logic [TimeW-1:0] t0_ff, t0_in;
   logic [3*CompW-1:0] a_ff, a_in;
   logic [1:0] phase_ff, phase_in;
   logic seg_ff, seg_in;
   logic [TimeW:0] tick_rem_ff, tick_rem_in;
   logic [5:0] tick_cnt_ff, tick_cnt_in;
   logic [DivBits-1:0] quo_ff, quo_in;
   logic [TimeW:0] rem_ff, rem_in;
   logic [TimeW-1:0] dvs_ff, dvs_in;
   logic [5:0] dcnt_ff, dcnt_in;
   logic [1:0] bcomp_ff, bcomp_in;
   logic [3*CompW-1:0] out_vec_ff, out_vec_in;
   logic [TimeW-1:0] out_time_ff, out_time_in;
   logic signed [CompW:0] diff;
   logic signed [CompW+17:0] prod;
   logic [TimeW:0] rem_shift;
   logic [TimeW+1:0] tick_shift;

   always_comb begin
      if (key_count == '0) n_use = CntW'(1);
      else if (key_count > CntW'(MaxKeys)) n_use = CntW'(MaxKeys);
      else n_use = key_count;
   end

   assign rd_addr = ctrl.write_key ? key_index : idx_ff[IdxW-1:0];

   always_ff @(posedge clock) begin
      if (ctrl.write_key) begin
         times_mem[rd_addr] <= key_time;
         vec_mem[rd_addr] <= {key_z, key_y, key_x};
      end
      rd_time_ff <= times_mem[rd_addr];
      rd_vec_ff <= vec_mem[rd_addr];
   end

   assign tick_shift = {tick_rem_ff, play_ff[TimeW-1]};
   assign rem_shift = {rem_ff[TimeW-1:0], quo_ff[DivBits-1]};
   assign diff = $signed({rd_vec_ff[bcomp_ff*CompW+CompW-1], rd_vec_ff[bcomp_ff*CompW +: CompW]})
               - $signed({a_ff[bcomp_ff*CompW+CompW-1], a_ff[bcomp_ff*CompW +: CompW]});
   assign prod = diff * $signed({1'b0, quo_ff[16:0]});

   always_comb begin
      play_in = play_ff;
      tick_rem_in = tick_rem_ff;
      tick_cnt_in = tick_cnt_ff;
      sample_in = sample_ff;
      idx_in = idx_ff;
      t0_in = t0_ff;
      a_in = a_ff;
      phase_in = phase_ff;
      seg_in = seg_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      dcnt_in = dcnt_ff;
      bcomp_in = bcomp_ff;
      out_vec_in = out_vec_ff;
      out_time_in = out_time_ff;
      status.tick_done = 1'b0;
      status.search_hit = 1'b0;
      status.search_end = 1'b0;
      status.div_done = (dcnt_ff == '0);
      // restoring modulo: sum is 25 bits, reduce by shifting bits through
      if (ctrl.start_tick) begin
         play_in = play_ff + time_step;
         tick_rem_in = {24'd0, (play_ff + time_step) < play_ff};
         tick_cnt_in = 6'd24;
      end else if (tick_cnt_ff != '0) begin
         if (tick_shift >= {2'b0, track_duration}) begin
            tick_rem_in = (TimeW+1)'(tick_shift - {2'b0, track_duration});
         end else begin
            tick_rem_in = tick_shift[TimeW:0];
         end
         play_in = {play_ff[TimeW-2:0], 1'b0};
         tick_cnt_in = tick_cnt_ff - 6'd1;
         if (tick_cnt_ff == 6'd1) begin
            play_in = (track_duration <= TimeW'(1)) ? '0 : tick_rem_in[TimeW-1:0];
            status.tick_done = 1'b1;
         end
      end
      if (ctrl.load_time) begin
         sample_in = use_playback ? play_ff : query_time;
         idx_in = '0;
         phase_in = 2'd0;
         seg_in = 1'b0;
      end
      if (ctrl.compare) begin
         // phase 0 read key0; phase 1 t0 held from key idx-1, reading key idx
         if (phase_ff == 2'd0) begin
            a_in = rd_vec_ff;
            t0_in = rd_time_ff;
            if (n_use == CntW'(1) || sample_ff <= rd_time_ff) begin
               status.search_end = 1'b1;
            end else begin
               idx_in = CntW'(1);
               phase_in = 2'd1;
            end
         end else begin
            if (t0_ff <= sample_ff && sample_ff <= rd_time_ff) begin
               status.search_hit = 1'b1;
               seg_in = 1'b1;
            end else if (idx_ff + CntW'(1) >= n_use) begin
               a_in = rd_vec_ff;
               status.search_end = 1'b1;
            end else begin
               a_in = rd_vec_ff;
               t0_in = rd_time_ff;
               idx_in = idx_ff + CntW'(1);
            end
         end
      end
      if (ctrl.div_start) begin
         quo_in = {sample_ff - t0_ff, 16'd0};
         rem_in = '0;
         dvs_in = rd_time_ff - t0_ff;
         dcnt_in = (rd_time_ff == t0_ff) ? 6'd0 : 6'(DivBits);
         if (rd_time_ff == t0_ff) quo_in = '0;
         bcomp_in = 2'd0;
      end else if (dcnt_ff != '0) begin
         if (rem_shift >= {1'b0, dvs_ff}) begin
            rem_in = rem_shift - {1'b0, dvs_ff};
            quo_in = {quo_ff[DivBits-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            quo_in = {quo_ff[DivBits-2:0], 1'b0};
         end
         dcnt_in = dcnt_ff - 6'd1;
      end
      if (ctrl.blend) begin
         out_vec_in[bcomp_ff*CompW +: CompW] =
            a_ff[bcomp_ff*CompW +: CompW] + CompW'(prod >>> 16);
         bcomp_in = bcomp_ff + 2'd1;
      end
      if (ctrl.load_out) begin
         out_time_in = sample_ff;
         if (!seg_ff) out_vec_in = a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         play_ff <= '0;
         tick_cnt_ff <= '0;
         dcnt_ff <= '0;
      end else begin
         play_ff <= play_in;
         tick_cnt_ff <= tick_cnt_in;
         dcnt_ff <= dcnt_in;
      end
      tick_rem_ff <= tick_rem_in;
      sample_ff <= sample_in;
      idx_ff <= idx_in;
      t0_ff <= t0_in;
      a_ff <= a_in;
      phase_ff <= phase_in;
      seg_ff <= seg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      bcomp_ff <= bcomp_in;
      out_vec_ff <= out_vec_in;
      out_time_ff <= out_time_in;
   end

   assign res_vec = out_vec_ff;
   assign res_time = out_time_ff;
endmodule

// ===== hw/rtl/kti_controller.sv =====
// Controller state machine: sequences write, tick, search, divide and blend.
// Depends on kti_pkg.
module kti_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_command,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  use_playback,
   output kti_pkg::ctrl_type     ctrl,
   input  kti_pkg::status_type   status
);
   import kti_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_TICK = 4'd1;
   localparam logic [3:0] S_LOAD = 4'd2;
   localparam logic [3:0] S_READ = 4'd3;
   localparam logic [3:0] S_CMP = 4'd4;
   localparam logic [3:0] S_DIV = 4'd5;
   localparam logic [3:0] S_BLEND = 4'd6;
   localparam logic [3:0] S_OUT = 4'd7;
   localparam logic [3:0] S_HOLD = 4'd8;
   localparam logic [3:0] S_DSTART = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [1:0] bcnt_ff, bcnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign use_playback = (state_ff == S_LOAD);

   always_comb begin
      state_in = state_ff;
      bcnt_in = bcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctrl = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_command)
                  CMD_WRITE: ctrl.write_key = 1'b1;
                  CMD_SAMPLE: begin
                     ctrl.load_time = 1'b1;
                     state_in = S_READ;
                  end
                  CMD_TICK: begin
                     ctrl.start_tick = 1'b1;
                     state_in = S_TICK;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_TICK: if (status.tick_done) state_in = S_LOAD;
         S_LOAD: begin
            ctrl.load_time = 1'b1;
            state_in = S_READ;
         end
         S_READ: state_in = S_CMP;
         S_CMP: begin
            ctrl.compare = 1'b1;
            if (status.search_hit) state_in = S_DSTART;
            else if (status.search_end) state_in = S_OUT;
            else state_in = S_READ;
         end
         S_DSTART: begin
            ctrl.div_start = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            bcnt_in = 2'd0;
            if (status.div_done) state_in = S_BLEND;
         end
         S_BLEND: begin
            ctrl.blend = 1'b1;
            bcnt_in = bcnt_ff + 2'd1;
            if (bcnt_ff == 2'd2) state_in = S_OUT;
         end
         S_OUT: begin
            ctrl.load_out = 1'b1;
            state_in = S_HOLD;
         end
         S_HOLD: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         bcnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bcnt_ff <= bcnt_in;
      end
   end
endmodule

// ===== hw/rtl/keyframe_track_interpolator.sv =====
// Keyframe track interpolator: linear keyframe interpolation over a 3-vector.
// Channels: request req (kti_req_if), result rsp (kti_rsp_if), registers csr_ (APB).
// A write transaction (command 0) loads one key and returns nothing; command 1
// samples at query_time; command 2 advances playback time, wraps it at the
// duration and samples there; command 3 is dropped without a result.
// One transaction is in flight at a time; a write frees the input next cycle.
// From acceptance, a sample loads its time and runs a linear search over the
// keys, one at a time; an interpolated sample then starts the serial divider,
// runs it and blends the three components in turn before the result is
// registered. A tick first runs the serial modulo of the playback time.
// The next transaction is accepted the cycle after the result is taken.
// Results wait in an output register while the receiver stalls; no new
// transaction is accepted until the pending result has been taken.
// Synchronous active-high reset clears control, playback time and registers:
// key_count 1, track_duration 65536, time_step 1092. Keys are undefined until
// written. Configuration (csr_) is to be written by the user only while the
// block is idle; the block itself does not enforce this.
// Depends on kti_pkg, kti_stream_if, kti_controller, kti_datapath, macros.
`include "keyframe_track_interpolator_macros.svh"
module keyframe_track_interpolator (
   input  logic         clock,
   input  logic         reset,
   kti_req_if.sink      req,
   kti_rsp_if.source    rsp,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import kti_pkg::*;

   logic [8:0] key_count_ff;
   logic [23:0] duration_ff;
   logic [23:0] step_ff;
   ctrl_type ctrl;
   status_type status;
   logic use_playback;
   logic [95:0] res_vec;
   logic csr_wr;
   logic write_fire;
   logic [3:0] dp_cmds;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= 9'd1;
         duration_ff <= 24'd65536;
         step_ff <= 24'd1092;
      end else if (csr_wr) begin
         unique case (csr_paddr)
            ADDR_KEY_COUNT: key_count_ff <= csr_pwdata[8:0];
            ADDR_DURATION: duration_ff <= csr_pwdata[23:0];
            ADDR_STEP: step_ff <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         ADDR_KEY_COUNT: csr_prdata = {23'd0, key_count_ff};
         ADDR_DURATION: csr_prdata = {8'd0, duration_ff};
         ADDR_STEP: csr_prdata = {8'd0, step_ff};
         default: csr_prdata = '0;
      endcase
   end

   kti_controller u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_command(req.command),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .use_playback(use_playback), .ctrl(ctrl), .status(status)
   );

   kti_datapath u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .status(status),
      .key_index(req.key_index), .key_time(req.key_time),
      .key_x(req.key_x), .key_y(req.key_y), .key_z(req.key_z),
      .query_time(req.query_time), .use_playback(use_playback),
      .key_count(key_count_ff), .track_duration(duration_ff), .time_step(step_ff),
      .res_vec(res_vec), .res_time(rsp.sampled_time)
   );

   assign rsp.out_x = res_vec[31:0];
   assign rsp.out_y = res_vec[63:32];
   assign rsp.out_z = res_vec[95:64];

   assign write_fire = req.valid && req.ready && (req.command == CMD_WRITE);
   assign dp_cmds = {ctrl.compare, ctrl.blend, ctrl.load_out, ctrl.div_start};

   `KTI_ASSERT_IMP(a_no_accept_pending, clock, reset, rsp.valid, !req.ready, "accept while busy")
   `KTI_ASSERT_NEXT(a_write_no_rsp, clock, reset, write_fire, !rsp.valid, "write gave a result")
   `KTI_ASSERT_IMP(a_ctrl_onehot, clock, reset, 1'b1, $onehot0(dp_cmds), "conflicting commands")
endmodule

// ===== bench/kti_tb_if.sv =====
`timescale 1ns / 100ps
// Constants for the bench top: run limits and the unused command code.
// Depends on nothing.
package kti_tb_pkg;
   localparam int TxnLimit = 10000000;
   localparam int DrainCycles = 1200;
   localparam logic [1:0] CMD_RESERVED = 2'd3;
endpackage

// ===== bench/kti_track_checker.sv =====
`timescale 1ns / 100ps
// Track checker: watches the request, result and register channels, predicts
// each sample and compares all its fields. Depends on kti_pkg, kti_stream_if.
module kti_track_checker (
   input  logic        clock,
   input  logic        reset,
   kti_req_if          req,
   kti_rsp_if          rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          error_count,
   output int          pending
);
   import kti_pkg::*;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [23:0]        stamp;
   } sample_type;

   sample_type          expected_samples[$];
   logic [23:0]         key_time_tab[MaxKeys];
   logic signed [31:0]  key_vec_tab[MaxKeys][3];
   logic [8:0]          keys_reg;
   logic [23:0]         duration_reg;
   logic [23:0]         step_reg;
   logic [23:0]         play_time;

   function automatic logic signed [31:0] lerp(logic signed [31:0] a,
                                               logic signed [31:0] b,
                                               longint t);
      longint prod;
      prod = (longint'(b) - longint'(a)) * t;
      return 32'(longint'(a) + (prod >>> 16));
   endfunction

   function automatic sample_type interpolate(logic [23:0] at);
      int         n;
      int         sel;
      bit         seg;
      longint     t;
      sample_type s;
      n = (keys_reg == 0) ? 1 : (keys_reg > MaxKeys ? MaxKeys : int'(keys_reg));
      sel = n - 1;
      seg = 0;
      t = 0;
      if (n == 1 || at <= key_time_tab[0]) begin
         sel = 0;
      end else begin
         for (int i = 0; i + 1 < n; i++) begin
            if (key_time_tab[i] <= at && at <= key_time_tab[i+1]) begin
               if (key_time_tab[i+1] != key_time_tab[i])
                  t = ((longint'(at) - key_time_tab[i]) <<< 16) /
                      (longint'(key_time_tab[i+1]) - key_time_tab[i]);
               sel = i;
               seg = 1;
               break;
            end
         end
      end
      s.x = key_vec_tab[sel][0];
      s.y = key_vec_tab[sel][1];
      s.z = key_vec_tab[sel][2];
      if (seg) begin
         s.x = lerp(s.x, key_vec_tab[sel+1][0], t);
         s.y = lerp(s.y, key_vec_tab[sel+1][1], t);
         s.z = lerp(s.z, key_vec_tab[sel+1][2], t);
      end
      s.stamp = at;
      return s;
   endfunction

   assign pending = expected_samples.size();

   always @(posedge clock) begin
      sample_type got;
      sample_type want;
      if (reset) begin
         keys_reg <= 9'd1;
         duration_reg <= 24'd65536;
         step_reg <= 24'd1092;
         play_time = '0;
         expected_samples.delete();
         error_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            case (csr_paddr)
               ADDR_KEY_COUNT: keys_reg <= csr_pwdata[8:0];
               ADDR_DURATION: duration_reg <= csr_pwdata[23:0];
               ADDR_STEP: step_reg <= csr_pwdata[23:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            case (req.command)
               CMD_WRITE: begin
                  key_time_tab[req.key_index] = req.key_time;
                  key_vec_tab[req.key_index][0] = req.key_x;
                  key_vec_tab[req.key_index][1] = req.key_y;
                  key_vec_tab[req.key_index][2] = req.key_z;
               end
               CMD_SAMPLE:
                  expected_samples.insert(expected_samples.size(),
                                          interpolate(req.query_time));
               CMD_TICK: begin
                  if (duration_reg == 0)
                     play_time = '0;
                  else
                     play_time = 24'((longint'(play_time) + step_reg) % duration_reg);
                  expected_samples.insert(expected_samples.size(), interpolate(play_time));
               end
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.out_x, rsp.out_y, rsp.out_z, rsp.sampled_time};
            if (expected_samples.size() == 0) begin
               error_count <= error_count + 1;
               if (error_count < 10)
                  $display("unexpected sample x=%0d y=%0d z=%0d time=%0h",
                           got.x, got.y, got.z, got.stamp);
            end else begin
               want = expected_samples.pop_front();
               if (got !== want) begin
                  error_count <= error_count + 1;
                  if (error_count < 10)
                     $display("exp x=%0d y=%0d z=%0d t=%0h got x=%0d y=%0d z=%0d t=%0h",
                              want.x, want.y, want.z, want.stamp,
                              got.x, got.y, got.z, got.stamp);
               end
            end
         end
      end
   end
endmodule

// ===== bench/keyframe_track_interpolator_tb.sv =====
`timescale 1ns / 100ps
// Top of the interpolator bench: clock, reset, register writes and request
// stimulus with random gaps. Depends on kti_pkg, kti_tb_pkg, kti_stream_if, the DUT, the checker.
module keyframe_track_interpolator_tb;
   import kti_pkg::*;
   import kti_tb_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          error_count;
   int          pending;
   int          cycles = 0;
   int          keys_loaded;
   logic [23:0] last_key_time;

   kti_req_if req ();
   kti_rsp_if rsp ();

   keyframe_track_interpolator dut (
      .clock, .reset, .req(req.sink), .rsp(rsp.source),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   kti_track_checker checker_i (
      .clock, .reset, .req, .rsp,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .error_count, .pending
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > TxnLimit) begin
         $display("[keyframe_track_interpolator] ERROR");
         $finish;
      end
   end

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0)
         return $urandom_range(20, 120);
      return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
   endfunction

   // stall the receiver at random, with stall-free stretches
   initial begin
      rsp.ready = 0;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 3) == 0) begin
            rsp.ready = 0;
            repeat (gap_len()) @(negedge clock);
         end
         rsp.ready = 1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   task automatic csr_write(logic [3:0] addr, logic [31:0] data);
      csr_psel = 1;
      csr_penable = 0;
      csr_pwrite = 1;
      csr_paddr = addr;
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1;
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
   endtask

   task automatic send(logic [1:0] cmd, logic [7:0] idx, logic [23:0] ktime,
                       logic [31:0] kx, logic [31:0] ky, logic [31:0] kz,
                       logic [23:0] qtime);
      req.valid = 1;
      req.command = cmd;
      req.key_index = idx;
      req.key_time = ktime;
      req.key_x = kx;
      req.key_y = ky;
      req.key_z = kz;
      req.query_time = qtime;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
      req.valid = 0;
      repeat (gap_len()) @(negedge clock);
   endtask

   task automatic settle();
      while (pending != 0) @(negedge clock);
      repeat (700) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // load a non-decreasing track into slots 0..n-1; the caller sets key_count
   task automatic load_track(int n, int max_stride);
      logic [23:0] t;
      t = 24'($urandom_range(0, 4000));
      for (int i = 0; i < n; i++) begin
         send(CMD_WRITE, 8'(i), t, rand_comp(), rand_comp(), rand_comp(), 24'($urandom));
         last_key_time = t;
         if ($urandom_range(0, 9) == 0 || t > 24'hff0000)
            t = t;
         else
            t = t + 24'($urandom_range(1, max_stride));
      end
      if (n > keys_loaded)
         keys_loaded = n;
   endtask

   task automatic sample_burst(int count);
      logic [1:0]  cmd;
      logic [23:0] q;
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: cmd = CMD_SAMPLE;
            4, 5, 6, 7: cmd = CMD_TICK;
            8: cmd = CMD_RESERVED;
            default: cmd = CMD_WRITE;
         endcase
         case ($urandom_range(0, 4))
            0: q = 24'($urandom);
            1: q = last_key_time + 24'($urandom_range(0, 3));
            default: q = 24'($urandom_range(0, int'(last_key_time) + 100));
         endcase
         if (cmd == CMD_WRITE)
            send(cmd, 8'($urandom_range(0, keys_loaded - 1)),
                 24'($urandom_range(0, 50)) + last_key_time, rand_comp(), rand_comp(),
                 rand_comp(), q);
         else
            send(cmd, 8'($urandom), 24'($urandom), $urandom, $urandom, $urandom, q);
      end
   endtask

   initial begin
      int n;
      keys_loaded = 0;
      last_key_time = '0;
      reset = 1;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req.valid = 0;
      req.command = CMD_WRITE;
      req.key_index = '0;
      req.key_time = '0;
      req.key_x = '0;
      req.key_y = '0;
      req.key_z = '0;
      req.query_time = '0;
      repeat (5) @(negedge clock);
      reset = 0;

      // directed: key 0 only, extremes, equal times, unknown command
      send(CMD_WRITE, 8'd0, 24'd0, 32'h8000_0000, 32'h7fff_ffff, 32'd0, 24'd0);
      keys_loaded = 1;
      send(CMD_SAMPLE, 8'hff, 24'hffffff, '1, '1, '1, 24'hffffff);
      send(CMD_TICK, 8'd0, '0, '0, '0, '0, '0);
      send(CMD_RESERVED, 8'hff, 24'hffffff, '1, '1, '1, 24'hffffff);
      send(CMD_WRITE, 8'd1, 24'd100, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, '0);
      send(CMD_WRITE, 8'd2, 24'd100, 32'd5, 32'd6, 32'd7, '0);
      send(CMD_WRITE, 8'd3, 24'hffffff, 32'h8000_0000, 32'h0001_0000, 32'd1, '0);
      send(CMD_WRITE, 8'd255, 24'hffffff, '1, '1, '1, '0);
      keys_loaded = 4;
      last_key_time = 24'hffffff;
      settle();
      csr_write(ADDR_KEY_COUNT, 32'd4);
      send(CMD_SAMPLE, '0, '0, '0, '0, '0, 24'd0);
      send(CMD_SAMPLE, '0, '0, '0, '0, '0, 24'd50);
      send(CMD_SAMPLE, '0, '0, '0, '0, '0, 24'd100);
      send(CMD_SAMPLE, '0, '0, '0, '0, '0, 24'd101);
      send(CMD_SAMPLE, '0, '0, '0, '0, '0, 24'hfffffe);
      send(CMD_SAMPLE, '0, '0, '0, '0, '0, 24'hffffff);
      settle();
      csr_write(ADDR_DURATION, 32'd0);
      send(CMD_TICK, '0, '0, '0, '0, '0, '0);
      settle();
      csr_write(ADDR_DURATION, 32'hffffff);
      csr_write(ADDR_STEP, 32'hffffff);
      send(CMD_TICK, '0, '0, '0, '0, '0, '0);
      send(CMD_TICK, '0, '0, '0, '0, '0, '0);
      settle();
      csr_write(ADDR_DURATION, 32'd300);
      csr_write(ADDR_STEP, 32'd0);
      send(CMD_TICK, '0, '0, '0, '0, '0, '0);
      settle();
      csr_write(ADDR_KEY_COUNT, 32'd0);
      send(CMD_SAMPLE, '0, '0, '0, '0, '0, 24'd77);
      settle();

      // random phases: mostly small tracks, a few full ones
      for (int ph = 0; ph < 24; ph++) begin
         case (ph % 8)
            0: n = 256;
            1: n = 2;
            default: n = $urandom_range(2, 16);
         endcase
         load_track(n, (ph % 3 == 0) ? 65536 : 3000);
         settle();
         csr_write(ADDR_KEY_COUNT, (ph == 5) ? 32'h1ff : 32'(n));
         csr_write(ADDR_DURATION, (ph % 4 == 0) ? 32'($urandom_range(0, 16777215))
                                                : 32'(int'(last_key_time) + 200));
         csr_write(ADDR_STEP, (ph % 5 == 0) ? 32'($urandom_range(0, 16777215))
                                            : 32'($urandom_range(0, 2000)));
         sample_burst((n == 256) ? 20 : 35);
         settle();
      end
      csr_write(ADDR_KEY_COUNT, 32'd1);
      csr_write(ADDR_DURATION, 32'd65536);
      csr_write(ADDR_STEP, 32'd1092);
      sample_burst(20);
      while (pending != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (error_count == 0)
         $display("[keyframe_track_interpolator] OK");
      else
         $display("[keyframe_track_interpolator] ERROR");
      $finish;
   end
endmodule
